/* rtl/wwf_pkg.sv */
package wwf_pkg;

    localparam int MAX_LETTERS_DEF = 16;
    localparam int LIST_SLOTS_DEF  = 8;

    localparam int POS_W     = 5;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int LIST_W    = 64;
    localparam int PAT_W     = 128;

    localparam logic [7:0] WILDCARD_BYTE = 8'h5F;
    localparam logic [7:0] NEWLINE_BYTE  = 8'h0A;
    localparam logic [7:0] NUL_BYTE      = 8'h00;

    localparam logic [LEN_W-1:0]  REQ_LEN_RESET = LEN_W'(5);
    localparam logic [63:0]       PATTERN_RESET = 64'h5F5F_5F5F_5F5F_5F5F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REQ_LEN  = 3'd0,
        REG_PAT_LOW  = 3'd1,
        REG_PAT_HIGH = 3'd2,
        REG_EXCL     = 3'd3,
        REG_INCL     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [LEN_W-1:0]  req_len;
        logic [PAT_W-1:0]  pattern;
        logic [LIST_W-1:0] excl;
        logic [LIST_W-1:0] incl;
    } cfg_t;

    typedef struct packed {
        logic [7:0] letter;
        logic       last;
    } item_t;

    typedef struct packed {
        logic valid;
        logic word_ok;
    } word_res_t;

endpackage

/* rtl/wwf_cfg_regs.sv */
module wwf_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [wwf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wwf_pkg::CFG_W-1:0]     cfg_wdata,
    output wwf_pkg::cfg_t                 cfg
);
    import wwf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_REQ_LEN:  cfg_next.req_len          = cfg_wdata[LEN_W-1:0];
                REG_PAT_LOW:  cfg_next.pattern[63:0]    = cfg_wdata;
                REG_PAT_HIGH: cfg_next.pattern[127:64]  = cfg_wdata;
                REG_EXCL:     cfg_next.excl             = cfg_wdata;
                REG_INCL:     cfg_next.incl             = cfg_wdata;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.req_len <= REQ_LEN_RESET;
            cfg_reg.pattern <= {PATTERN_RESET, PATTERN_RESET};
            cfg_reg.excl    <= '0;
            cfg_reg.incl    <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/wwf_word_check.sv */
module wwf_word_check #(
    parameter int MAX_LETTERS = wwf_pkg::MAX_LETTERS_DEF,
    parameter int LIST_SLOTS  = wwf_pkg::LIST_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  wwf_pkg::item_t     item,
    input  wwf_pkg::cfg_t      cfg,
    output wwf_pkg::word_res_t res
);
    import wwf_pkg::*;

    localparam int CNT_W = $clog2(LIST_SLOTS + 1);

    logic [POS_W-1:0]      pos_reg,    pos_next;
    logic                  valid_reg,  valid_next;
    logic                  closed_reg, closed_next;
    logic [LIST_SLOTS-1:0] used_reg,   used_next;
    logic [CNT_W-1:0]      found_reg,  found_next;

    logic [LIST_SLOTS-1:0] excl_en, incl_en, excl_eq, incl_eq, cand, take;
    logic [7:0]            pat_byte;
    logic [CNT_W-1:0]      incl_len;
    logic                  is_term, excl_hit;
    logic                  upd_valid;
    logic [POS_W-1:0]      upd_pos;

    // list enables: slot counts only up to the first zero byte
    always_comb begin
        for (int k = 0; k < LIST_SLOTS; k++) begin
            excl_eq[k] = (cfg.excl[8*k +: 8] == item.letter);
            incl_eq[k] = (cfg.incl[8*k +: 8] == item.letter);
            if (k == 0) begin
                excl_en[k] = (cfg.excl[7:0] != NUL_BYTE);
                incl_en[k] = (cfg.incl[7:0] != NUL_BYTE);
            end else begin
                excl_en[k] = excl_en[k-1] && (cfg.excl[8*k +: 8] != NUL_BYTE);
                incl_en[k] = incl_en[k-1] && (cfg.incl[8*k +: 8] != NUL_BYTE);
            end
        end
    end

    assign incl_len = CNT_W'($countones(incl_en));
    assign excl_hit = |(excl_en & excl_eq);
    assign cand     = incl_en & incl_eq & ~used_reg;
    assign take     = cand & (~cand + LIST_SLOTS'(1));   // lowest free matching slot
    assign pat_byte = cfg.pattern[8*pos_reg[3:0] +: 8];
    assign is_term  = (item.letter == NUL_BYTE) || (item.letter == NEWLINE_BYTE);

    always_comb begin
        upd_pos     = pos_reg;
        upd_valid   = valid_reg;
        closed_next = closed_reg;
        used_next   = used_reg;
        found_next  = found_reg;
        if (!closed_reg && valid_reg) begin
            if (is_term) begin
                closed_next = 1'b1;
            end else if (pos_reg >= POS_W'(MAX_LETTERS)) begin
                upd_valid = 1'b0;
            end else begin
                if (pat_byte == WILDCARD_BYTE) begin
                    if (excl_hit) begin
                        upd_valid = 1'b0;
                    end else begin
                        used_next  = used_reg | take;
                        found_next = found_reg + CNT_W'(|cand);
                    end
                end else begin
                    upd_valid = (item.letter == pat_byte);
                end
                upd_pos = pos_reg + POS_W'(1);
                if (upd_valid && (upd_pos > cfg.req_len)) begin
                    upd_valid = 1'b0;
                end
            end
        end
        pos_next   = upd_pos;
        valid_next = upd_valid;
    end

    assign res.valid   = fire && item.last;
    assign res.word_ok = upd_valid
                      && (cfg.req_len >= LEN_W'(1))
                      && (cfg.req_len <= LEN_W'(MAX_LETTERS))
                      && (upd_pos == cfg.req_len)
                      && (found_next == incl_len);

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && item.last)) begin
            pos_reg    <= '0;
            valid_reg  <= 1'b1;
            closed_reg <= 1'b0;
            used_reg   <= '0;
            found_reg  <= '0;
        end else if (fire) begin
            pos_reg    <= pos_next;
            valid_reg  <= valid_next;
            closed_reg <= closed_next;
            used_reg   <= used_next;
            found_reg  <= found_next;
        end
    end

    a_found_tracks_used: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg == CNT_W'($countones(used_reg)))
        else $error("found count out of step with used slots");

    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_LETTERS))
        else $error("position beyond letter limit");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.last) |=> (pos_reg == '0) && valid_reg && !closed_reg
                                && (used_reg == '0))
        else $error("word state not cleared after last letter");

endmodule

/* rtl/wildcard_word_filter_core.sv */
// Path: an input transfer lands in the input register; a final letter then
// goes through the check logic into the result register.
// Throughput: one letter per cycle; the only stall is a final letter while
// the result register still holds an untaken result.
// Reset (aresetn, synchronous, active low): clears the word state and both
// handshake stages and loads the configuration registers with their defaults.
module wildcard_word_filter_core #(
    parameter int MAX_LETTERS = wwf_pkg::MAX_LETTERS_DEF,
    parameter int LIST_SLOTS  = wwf_pkg::LIST_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] letter
    input  logic                          s_tlast,   // end_of_word
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [0] word_matches, [7:1] zero
    input  logic                          cfg_wr_en,
    input  logic [wwf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wwf_pkg::CFG_W-1:0]     cfg_wdata
);
    import wwf_pkg::*;

    cfg_t      cfg;
    item_t     in_item_reg;
    logic      in_valid_reg;
    logic      out_valid_reg;
    logic      out_match_reg;
    logic      out_free;
    logic      proc_fire;
    word_res_t res;

    wwf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    wwf_word_check #(
        .MAX_LETTERS (MAX_LETTERS),
        .LIST_SLOTS  (LIST_SLOTS)
    ) u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (proc_fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // only a final letter needs room in the result register
    assign out_free  = !out_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && (!in_item_reg.last || out_free);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.letter <= s_tdata;
            in_item_reg.last   <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            out_match_reg <= res.word_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_match_reg};

endmodule
